// File: design/ysr_pkg.sv
// Package for the YUV to RGB24 converter: pixel type, chroma mode codes,
// BT.601 weights and the reuse-count lookup. No dependencies.
package ysr_pkg;

   localparam logic [1:0] MODE_444 = 2'd0;
   localparam logic [1:0] MODE_422 = 2'd1;
   localparam logic [1:0] MODE_411 = 2'd2;

   localparam logic [2:0] PHASE_DUE = 3'd4;

   localparam int ACC_W = 19;

   localparam logic signed [ACC_W-1:0] W_Y   = 19'sd298;
   localparam logic signed [ACC_W-1:0] W_RV  = 19'sd409;
   localparam logic signed [ACC_W-1:0] W_GU  = 19'sd100;
   localparam logic signed [ACC_W-1:0] W_GV  = 19'sd208;
   localparam logic signed [ACC_W-1:0] W_BU  = 19'sd516;
   localparam logic signed [ACC_W-1:0] ROUND = 19'sd128;
   localparam logic signed [ACC_W-1:0] Y_OFS = 19'sd16;
   localparam logic signed [ACC_W-1:0] C_OFS = 19'sd128;

   localparam logic [7:0] CHROMA_RESET = 8'd128;

   typedef struct packed {
      logic [7:0] y;
      logic [7:0] u;
      logic [7:0] v;
   } pix_type;

   function automatic logic [2:0] reuse_count(input logic [1:0] mode);
      logic [2:0] cnt;
      case (mode)
         MODE_422: cnt = 3'd2;
         MODE_411: cnt = 3'd4;
         default:  cnt = 3'd1;
      endcase
      return cnt;
   endfunction

endpackage

// File: design/ysr_chroma.sv
// Input stage: holds the chroma mode register, tracks the chroma phase and
// the held U/V pair, and registers each pixel with its resolved chroma.
// Depends on ysr_pkg.
module ysr_chroma import ysr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic [1:0] csr_chroma_mode,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_y_sample,
   input  logic [7:0] req_u_sample,
   input  logic [7:0] req_v_sample,
   input  logic       req_frame_start,
   output logic       pix_valid,
   output pix_type    pix,
   input  logic       pix_stall
);

   logic [1:0] mode_ff;
   logic [2:0] phase_ff, phase_in;
   logic [7:0] held_u_ff, held_u_in;
   logic [7:0] held_v_ff, held_v_in;
   logic       valid_ff, valid_in;
   pix_type    pix_ff, pix_in;
   logic       accept;
   logic       take_new;

   assign req_stall = valid_ff && pix_stall;
   assign accept    = req_valid && !req_stall;
   assign take_new  = req_frame_start || (phase_ff >= reuse_count(mode_ff));

   always_comb begin
      phase_in  = phase_ff;
      held_u_in = held_u_ff;
      held_v_in = held_v_ff;
      valid_in  = valid_ff;
      pix_in    = pix_ff;
      if (accept) begin
         if (take_new) begin
            held_u_in = req_u_sample;
            held_v_in = req_v_sample;
            phase_in  = 3'd1;
         end else begin
            phase_in = phase_ff + 3'd1;
         end
         valid_in = 1'b1;
         pix_in.y = req_y_sample;
         pix_in.u = held_u_in;
         pix_in.v = held_v_in;
      end else if (!pix_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_444;
         phase_ff  <= PHASE_DUE;
         held_u_ff <= CHROMA_RESET;
         held_v_ff <= CHROMA_RESET;
         valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            mode_ff <= csr_chroma_mode;
         end
         phase_ff  <= phase_in;
         held_u_ff <= held_u_in;
         held_v_ff <= held_v_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign pix_valid = valid_ff;
   assign pix       = pix_ff;

endmodule

// File: design/ysr_convert.sv
// Output stage: BT.601 integer color matrix with rounding, shift and clamp,
// feeding the result register of the response channel. Depends on ysr_pkg.
module ysr_convert import ysr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       pix_valid,
   input  pix_type    pix,
   output logic       pix_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue
);

   logic                    valid_ff;
   logic [7:0]              red_ff, red_in;
   logic [7:0]              green_ff, green_in;
   logic [7:0]              blue_ff, blue_in;
   logic                    advance;
   logic signed [ACC_W-1:0] c, d, e;
   logic signed [ACC_W-1:0] yc, acc_r, acc_g, acc_b;

   function automatic logic [7:0] clamp_shift(input logic signed [ACC_W-1:0] acc);
      logic [7:0] res;
      if (acc < 0) begin
         res = 8'd0;
      end else if (acc[ACC_W-1:16] != '0) begin
         res = 8'd255;
      end else begin
         res = acc[15:8];
      end
      return res;
   endfunction

   assign advance   = !valid_ff || !rsp_stall;
   assign pix_stall = !advance;

   always_comb begin
      c  = $signed({{(ACC_W-8){1'b0}}, pix.y}) - Y_OFS;
      d  = $signed({{(ACC_W-8){1'b0}}, pix.u}) - C_OFS;
      e  = $signed({{(ACC_W-8){1'b0}}, pix.v}) - C_OFS;
      yc = W_Y * c + ROUND;
      acc_r = yc + W_RV * e;
      acc_g = yc - W_GU * d - W_GV * e;
      acc_b = yc + W_BU * d;
      red_in   = clamp_shift(acc_r);
      green_in = clamp_shift(acc_g);
      blue_in  = clamp_shift(acc_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= pix_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && pix_valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

// File: design/yuv_subsampled_to_rgb24_top.sv
// Top level of the subsampled YUV to RGB24 converter.
// Instantiates ysr_chroma and ysr_convert; depends on ysr_pkg.
//
// Usage: one pixel per transfer on the req_ channel (luma, U/V, frame
// start); one RGB24 pixel per transfer on the rsp_ channel. A transfer
// happens at a rising edge where valid is high and stall is low.
// The csr_ port writes the chroma mode (4:4:4, 4:2:2 or 4:1:1); write it
// only while no pixel is in flight. U/V are sampled only on pixels where a
// new chroma pair is due, and frame start forces a new pair.
// A pixel taken goes into the input register, and its result then into the
// output register. Throughput is one pixel per cycle while the receiver
// does not stall, set by the two register stages.
// When the receiver stalls, the result holds, the input register fills,
// and then req_stall rises; new pixels are taken again as soon as the
// result is transferred. Reset empties both stages, sets the mode to 4:4:4
// and the held chroma pair to 128, with a new pair due on the next pixel.
module yuv_subsampled_to_rgb24_top import ysr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic [1:0] csr_chroma_mode,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_y_sample,
   input  logic [7:0] req_u_sample,
   input  logic [7:0] req_v_sample,
   input  logic       req_frame_start,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue
);

   logic    pix_valid;
   logic    pix_stall;
   pix_type pix;

   ysr_chroma u_chroma (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_chroma_mode (csr_chroma_mode),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_y_sample    (req_y_sample),
      .req_u_sample    (req_u_sample),
      .req_v_sample    (req_v_sample),
      .req_frame_start (req_frame_start),
      .pix_valid       (pix_valid),
      .pix             (pix),
      .pix_stall       (pix_stall)
   );

   ysr_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (pix_valid),
      .pix       (pix),
      .pix_stall (pix_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );

endmodule

// File: test/ysr_pixel_checker.sv
// Pixel checker for the YUV to RGB24 converter: tracks chroma mode writes,
// predicts each RGB24 pixel from the accepted YUV transfers and compares it
// with the rsp_ channel. Depends on ysr_pkg.
module ysr_pixel_checker import ysr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic [1:0] csr_chroma_mode,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_y_sample,
   input  logic [7:0] req_u_sample,
   input  logic [7:0] req_v_sample,
   input  logic       req_frame_start,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_red,
   input  logic [7:0] rsp_green,
   input  logic [7:0] rsp_blue,
   output int         error_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_pixel_type;

   rgb_pixel_type expected_rgb[$];
   logic [1:0] chroma_mode;
   logic [2:0] chroma_phase;
   logic [7:0] held_u;
   logic [7:0] held_v;

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   function automatic logic [7:0] clip_to_byte(input int acc);
      if (acc < 0) return 8'd0;
      if (acc >= 65536) return 8'd255;
      return acc[15:8];
   endfunction

   function automatic logic [2:0] pixels_per_pair(input logic [1:0] mode);
      case (mode)
         MODE_422: return 3'd2;
         MODE_411: return 3'd4;
         default:  return 3'd1;
      endcase
   endfunction

   function automatic rgb_pixel_type bt601_convert(input logic [7:0] y, u, v);
      int c;
      int d;
      int e;
      rgb_pixel_type pix;
      c = int'(y) - 16;
      d = int'(u) - 128;
      e = int'(v) - 128;
      pix.red   = clip_to_byte(298 * c + 409 * e + 128);
      pix.green = clip_to_byte(298 * c - 100 * d - 208 * e + 128);
      pix.blue  = clip_to_byte(298 * c + 516 * d + 128);
      return pix;
   endfunction

   always @(posedge clock) begin
      rgb_pixel_type want;
      if (reset) begin
         expected_rgb.delete();
         chroma_mode = MODE_444;
         chroma_phase = PHASE_DUE;
         held_u = CHROMA_RESET;
         held_v = CHROMA_RESET;
      end else begin
         if (csr_write) begin
            chroma_mode = csr_chroma_mode;
         end
         if (req_valid && !req_stall) begin
            if (req_frame_start || chroma_phase >= pixels_per_pair(chroma_mode)) begin
               held_u = req_u_sample;
               held_v = req_v_sample;
               chroma_phase = 3'd0;
            end
            chroma_phase = chroma_phase + 3'd1;
            expected_rgb.push_back(bt601_convert(req_y_sample, held_u, held_v));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rgb.size() == 0) begin
               $display("%0t: pixel transfer with none expected, actual R %0d G %0d B %0d",
                        $time, rsp_red, rsp_green, rsp_blue);
               error_count++;
            end else begin
               want = expected_rgb.pop_front();
               if (rsp_red !== want.red) begin
                  $display("%0t: red mismatch, expected %0d, actual %0d",
                           $time, want.red, rsp_red);
                  error_count++;
               end
               if (rsp_green !== want.green) begin
                  $display("%0t: green mismatch, expected %0d, actual %0d",
                           $time, want.green, rsp_green);
                  error_count++;
               end
               if (rsp_blue !== want.blue) begin
                  $display("%0t: blue mismatch, expected %0d, actual %0d",
                           $time, want.blue, rsp_blue);
                  error_count++;
               end
            end
         end
      end
      pending_count <= expected_rgb.size();
   end

endmodule

// File: test/testbench.sv
// Top of the YUV to RGB24 converter test: clock, reset, pixel and chroma mode
// stimulus, random receiver stalls and the verdict. Depends on ysr_pkg,
// ysr_pixel_checker and the converter itself.
module testbench import ysr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 5000;
   localparam int RANDOM_PIXELS = 1300;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write;
   logic [1:0] csr_chroma_mode;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_y_sample;
   logic [7:0] req_u_sample;
   logic [7:0] req_v_sample;
   logic       req_frame_start;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   int         error_count;
   int         pending_count;
   int         quiet_cycles = 0;
   bit         idle_gaps = 1'b0;

   always #10 clock = ~clock;

   yuv_subsampled_to_rgb24_top dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_chroma_mode (csr_chroma_mode),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_y_sample    (req_y_sample),
      .req_u_sample    (req_u_sample),
      .req_v_sample    (req_v_sample),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue)
   );

   ysr_pixel_checker u_pixel_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_chroma_mode (csr_chroma_mode),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_y_sample    (req_y_sample),
      .req_u_sample    (req_u_sample),
      .req_v_sample    (req_v_sample),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .error_count     (error_count),
      .pending_count   (pending_count)
   );

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [7:0] sample_byte();
      int r;
      r = $urandom_range(0, 15);
      case (r)
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd16;
         3: return 8'd235;
         4: return 8'd128;
         5: return 8'd240;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixel(input logic [7:0] y, u, v, input logic frame_start);
      int gap;
      gap = idle_gaps ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_y_sample <= y;
      req_u_sample <= u;
      req_v_sample <= v;
      req_frame_start <= frame_start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic set_chroma_mode(input logic [1:0] mode);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write <= 1'b1;
      csr_chroma_mode <= mode;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Receiver: free runs of varying length alternate with stalls.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(40, 150)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_stall <= 1'b1;
         repeat (gap_length() + 1) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [1:0] chroma_modes[4];
      int sent;
      int run_len;
      chroma_modes = '{MODE_444, MODE_422, MODE_411, MODE_UNUSED};
      reset = 1'b1;
      csr_write = 1'b0;
      csr_chroma_mode = MODE_444;
      req_valid = 1'b0;
      req_y_sample = 8'd0;
      req_u_sample = 8'd0;
      req_v_sample = 8'd0;
      req_frame_start = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // The first pixel after reset takes a new chroma pair without a frame start.
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd16, 8'd128, 8'd128, 1'b0);
      send_pixel(8'd235, 8'd128, 8'd128, 1'b0);
      send_pixel(8'd128, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd128, 8'd255, 8'd255, 1'b0);

      // In 4:1:1 the chroma of the three pixels after a pair is ignored.
      set_chroma_mode(MODE_411);
      send_pixel(8'd81, 8'd90, 8'd240, 1'b1);
      send_pixel(8'd145, 8'd54, 8'd34, 1'b0);
      send_pixel(8'd41, 8'd240, 8'd110, 1'b0);
      send_pixel(8'd170, 8'd166, 8'd16, 1'b0);
      send_pixel(8'd210, 8'd16, 8'd146, 1'b0);
      send_pixel(8'd106, 8'd202, 8'd222, 1'b0);

      // Mode changes in the middle of a pair's reuse.
      set_chroma_mode(MODE_422);
      send_pixel(8'd200, 8'd30, 8'd60, 1'b0);
      send_pixel(8'd50, 8'd220, 8'd20, 1'b0);
      set_chroma_mode(MODE_411);
      send_pixel(8'd90, 8'd100, 8'd100, 1'b0);
      send_pixel(8'd90, 8'd10, 8'd250, 1'b0);

      // The unused mode code behaves as 4:4:4.
      set_chroma_mode(MODE_UNUSED);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd128, 8'd128, 8'd128, 1'b1);

      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         set_chroma_mode(chroma_modes[$urandom_range(0, 3)]);
         idle_gaps = ($urandom_range(0, 3) != 0);
         run_len = $urandom_range(40, 140);
         for (int i = 0; i < run_len; i++) begin
            send_pixel(sample_byte(), sample_byte(), sample_byte(),
                       (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 49) == 0));
         end
         sent += run_len;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
